@@ design/sds_pkg.sv @@
package sds_pkg;

	localparam int DelimMax = 8;
	localparam int IdxBits = (DelimMax > 1) ? $clog2(DelimMax) : 1;
	localparam int CntBits = $clog2(DelimMax + 2);
	localparam int TokenNumberBits = 16;

	localparam int CfgAddrBits = 5;
	localparam int RegIdxBits = 2;
	localparam logic [RegIdxBits-1:0] RegSplitMode = 2'd0;
	localparam logic [RegIdxBits-1:0] RegDelimBytes = 2'd1;
	localparam logic [RegIdxBits-1:0] RegDelimLength = 2'd2;

	localparam logic ModeWhitespace = 1'b0;
	localparam logic ModeDelimiter = 1'b1;

	localparam logic KindByte = 1'b0;
	localparam logic KindEnd = 1'b1;

	localparam int QueueDepth = 2;
	localparam int QueueIdxBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntBits = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic [7:0] char_byte;
		logic       string_end;
	} in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  token_char;
		logic [15:0] token_number;
		logic        run_last;
	} out_t;

	typedef struct packed {
		logic        split_mode;
		logic [63:0] delim_bytes;
		logic [3:0]  delim_length;
	} cfg_t;

	typedef struct packed {
		logic [DelimMax-1:0][7:0]     chars;
		logic [CntBits-1:0]           nbytes;
		logic                         close;
		logic [TokenNumberBits-1:0]   number;
	} job_t;

endpackage

@@ design/sds_fifo.sv @@
module sds_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sds_pkg::job_t     wr_data,
	output logic              full,
	input  logic              rd_en,
	output sds_pkg::job_t     rd_data,
	output logic              empty
);

	sds_pkg::job_t mem_q [sds_pkg::QueueDepth];
	logic [sds_pkg::QueueIdxBits-1:0] wr_ptr_q;
	logic [sds_pkg::QueueIdxBits-1:0] rd_ptr_q;
	logic [sds_pkg::QueueCntBits-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == sds_pkg::QueueCntBits'(sds_pkg::QueueDepth));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/sds_front.sv @@
module sds_front (
	input  logic            clk,
	input  logic            arst_n,
	input  sds_pkg::cfg_t   cfg,
	input  logic            push,
	input  sds_pkg::in_t    item,
	output logic            full,
	output logic            job_push,
	output sds_pkg::job_t   job,
	input  logic            job_full
);

	localparam int CB = sds_pkg::CntBits;
	localparam int IB = sds_pkg::IdxBits;
	localparam int DM = sds_pkg::DelimMax;

	logic [CB-1:0] m_q;
	logic          open_q;
	logic [sds_pkg::TokenNumberBits-1:0] tokens_q;

	logic [7:0]    d [DM];
	logic [7:0]    c;
	logic          last;
	logic          accept;
	logic          ws;
	logic [CB-1:0] len;
	logic [CB-1:0] m;
	logic [CB-1:0] k;
	logic [CB-1:0] rel_cnt;
	logic [CB-1:0] newm;
	logic [CB-1:0] held;
	logic          match;
	logic          hit;
	logic          ok;
	logic [DM-1:0][7:0] chars_dl;
	logic [CB-1:0] m_next;
	logic          open_next;

	function automatic logic is_ws(input logic [7:0] ch);
		return (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
	endfunction

	assign c = item.char_byte;
	assign last = item.string_end;
	assign accept = push && !job_full;
	assign full = job_full;
	assign ws = is_ws(c);

	always_comb begin
		for (int i = 0; i < DM; i++) begin
			d[i] = cfg.delim_bytes[8*i +: 8];
		end
	end

	always_comb begin
		len = (cfg.delim_length > CB'(DM)) ? CB'(DM) : CB'(cfg.delim_length);
		m = (m_q >= len) ? len - CB'(1) : m_q;
		match = (c == d[m[IB-1:0]]);
		hit = match && (CB'(m + CB'(1)) == len);

		k = '0;
		for (int kk = 1; kk < DM; kk++) begin
			ok = (CB'(kk) <= m) && (d[kk-1] == c);
			for (int i = 0; i < kk - 1; i++) begin
				if (d[i] != d[IB'(int'(m) + 1 + i - kk)]) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				k = CB'(kk);
			end
		end

		if (match) begin
			rel_cnt = '0;
			newm = hit ? '0 : CB'(m + CB'(1));
		end else begin
			rel_cnt = CB'(m + CB'(1) - k);
			newm = k;
		end
		held = (last && !hit) ? newm : '0;

		for (int j = 0; j < DM; j++) begin
			if (CB'(j) < rel_cnt) begin
				chars_dl[j] = (CB'(j) < m) ? d[j] : c;
			end else begin
				chars_dl[j] = d[IB'(CB'(j) - rel_cnt)];
			end
		end

		job.number = tokens_q;
		if (cfg.split_mode == sds_pkg::ModeWhitespace) begin
			job.chars = '0;
			job.chars[0] = c;
			job.nbytes = ws ? '0 : CB'(1);
			job.close = ws ? open_q : last;
			m_next = '0;
			open_next = !ws && !last;
		end else if (len == '0) begin
			job.chars = chars_dl;
			job.nbytes = '0;
			job.close = 1'b0;
			m_next = '0;
			open_next = 1'b0;
		end else begin
			job.chars = chars_dl;
			job.nbytes = CB'(rel_cnt + held);
			job.close = hit || last;
			m_next = last ? '0 : newm;
			open_next = 1'b0;
		end
	end

	assign job_push = accept && ((job.nbytes != '0) || job.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			open_q <= 1'b0;
			tokens_q <= '0;
		end else if (accept) begin
			m_q <= m_next;
			open_q <= open_next;
			if (last) begin
				tokens_q <= '0;
			end else if (job.close && (tokens_q != '1)) begin
				tokens_q <= tokens_q + 1'b1;
			end
		end
	end

endmodule

@@ design/sds_back.sv @@
module sds_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sds_pkg::job_t   job,
	input  logic            job_empty,
	output logic            job_pop,
	output sds_pkg::out_t   result,
	output logic            empty,
	input  logic            pop
);

	localparam int CB = sds_pkg::CntBits;
	localparam int IB = sds_pkg::IdxBits;

	sds_pkg::job_t job_q;
	logic          job_vld_q;
	logic [CB-1:0] pos_q;
	sds_pkg::out_t out_q;
	logic          out_vld_q;

	sds_pkg::out_t nxt;
	logic [CB-1:0] nres;
	logic          is_end;
	logic          adv;
	logic          done;

	always_comb begin
		nres = CB'(job_q.nbytes + CB'(job_q.close));
		is_end = (pos_q >= job_q.nbytes);
		nxt.result_kind = is_end ? sds_pkg::KindEnd : sds_pkg::KindByte;
		nxt.token_char = is_end ? 8'd0 : job_q.chars[pos_q[IB-1:0]];
		nxt.token_number = 16'(job_q.number);
		nxt.run_last = (CB'(pos_q + CB'(1)) == nres);
	end

	assign adv = job_vld_q && (!out_vld_q || pop);
	assign done = adv && nxt.run_last;
	assign job_pop = !job_empty && (!job_vld_q || done);
	assign result = out_q;
	assign empty = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (job_pop) begin
				job_vld_q <= 1'b1;
				pos_q <= '0;
			end else begin
				if (done) begin
					job_vld_q <= 1'b0;
				end
				if (adv) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= nxt;
		end
		if (job_pop) begin
			job_q <= job;
		end
	end

endmodule

@@ design/string_delimiter_splitter.sv @@
// Splits a byte string into tokens, either at whitespace runs or at a configured delimiter of up
// to eight bytes, and delivers token bytes and end-of-token marks one word per cycle while the
// receiver keeps popping. A byte is accepted in every cycle in which the two-entry job queue
// behind the classifying front end has room; the front end turns each byte into at most one job
// as it accepts it, and the back end emits the result words of a job one at a time, so one input
// byte yields between zero and nine result words (one in the common case), and the output side
// sets the sustained rate. Results pass the job queue, the job register and the output register.
module string_delimiter_splitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  sds_pkg::in_t                        item,
	output logic                                empty,
	input  logic                                pop,
	output sds_pkg::out_t                       result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sds_pkg::CfgAddrBits-1:0]     paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);

	sds_pkg::cfg_t cfg_q;
	logic [sds_pkg::RegIdxBits-1:0] reg_idx;
	logic cfg_wr;

	logic          job_push;
	logic          job_full;
	logic          job_pop;
	logic          job_empty;
	sds_pkg::job_t job_in;
	sds_pkg::job_t job_out;

	assign pready = 1'b1;
	assign reg_idx = paddr[sds_pkg::CfgAddrBits-1:3];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				sds_pkg::RegSplitMode: begin
					cfg_q.split_mode <= pwdata[0];
				end
				sds_pkg::RegDelimBytes: begin
					cfg_q.delim_bytes <= pwdata;
				end
				sds_pkg::RegDelimLength: begin
					cfg_q.delim_length <= pwdata[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sds_pkg::RegSplitMode: prdata = {63'd0, cfg_q.split_mode};
			sds_pkg::RegDelimBytes: prdata = cfg_q.delim_bytes;
			sds_pkg::RegDelimLength: prdata = {60'd0, cfg_q.delim_length};
			default: prdata = '0;
		endcase
	end

	sds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	sds_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	sds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ design/sds_checker.sv @@
module sds_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            empty,
	input logic                            pop,
	input sds_pkg::out_t                   result,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [sds_pkg::CfgAddrBits-1:0] paddr,
	input logic [63:0]                     pwdata,
	input logic [63:0]                     prdata,
	input logic                            pready
);

	// An end mark always closes the results of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.result_kind == sds_pkg::KindEnd) |-> result.run_last)
		else $error("end mark not last result of its byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.result_kind == sds_pkg::KindEnd) |-> (result.token_char == 8'd0))
		else $error("end mark carries a character");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result word changed or vanished");

	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
			&& (paddr[sds_pkg::CfgAddrBits-1:3] == sds_pkg::RegSplitMode)
		|=> (paddr[sds_pkg::CfgAddrBits-1:3] != sds_pkg::RegSplitMode)
			|| (prdata[0] == $past(pwdata[0])))
		else $error("split mode readback mismatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
			&& (paddr[sds_pkg::CfgAddrBits-1:3] == sds_pkg::RegDelimLength)
		|=> (paddr[sds_pkg::CfgAddrBits-1:3] != sds_pkg::RegDelimLength)
			|| (prdata[3:0] == $past(pwdata[3:0])))
		else $error("delimiter length readback mismatch");

endmodule

bind string_delimiter_splitter sds_checker u_sds_checker (.*);

@@ tb/tb_string_delimiter_splitter.sv @@
module tb_string_delimiter_splitter;

	localparam int unsigned CycleLimit = 3000000;
	localparam int unsigned DrainLimit = 20000;
	localparam int unsigned SettleCycles = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	sds_pkg::in_t item = '0;
	logic empty;
	logic pop = 1'b0;
	sds_pkg::out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [sds_pkg::CfgAddrBits-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	logic cfg_mode = sds_pkg::ModeWhitespace;
	logic [63:0] cfg_delim = '0;
	logic [3:0] cfg_dlen = '0;
	int unsigned held_cnt = 0;
	bit tok_open = 1'b0;
	logic [15:0] tok_count = '0;
	sds_pkg::out_t tok_expected[$];
	int unsigned step_words;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic [7:0] alpha0 = 8'h61;
	logic [7:0] alpha1 = 8'h62;

	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned words_checked = 0;
	int unsigned cfg_writes = 0;
	int unsigned cycle_count = 0;

	string_delimiter_splitter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : word_check
		sds_pkg::out_t want;
		if (arst_n && pop && !empty) begin
			if (tok_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected word kind=%0d char=%h num=%0d last=%0d", $time,
					result.result_kind, result.token_char, result.token_number,
					result.run_last);
			end else begin
				want = tok_expected.pop_front();
				words_checked++;
				if (want.result_kind !== result.result_kind ||
						want.token_char !== result.token_char ||
						want.token_number !== result.token_number ||
						want.run_last !== result.run_last) begin
					errors++;
					$display({"%0t: word mismatch expected kind=%0d char=%h num=%0d last=%0d,",
						" got kind=%0d char=%h num=%0d last=%0d"},
						$time, want.result_kind, want.token_char, want.token_number,
						want.run_last, result.result_kind, result.token_char,
						result.token_number, result.run_last);
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic bit is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] delim_at(input int unsigned i);
		return cfg_delim[8*(i%8) +: 8];
	endfunction

	function automatic void add_word(input logic kind, input logic [7:0] ch);
		sds_pkg::out_t w;
		w.result_kind = kind;
		w.token_char = ch;
		w.token_number = tok_count;
		w.run_last = 1'b0;
		tok_expected.push_back(w);
		step_words++;
	endfunction

	function automatic void close_token();
		add_word(sds_pkg::KindEnd, 8'h00);
		if (tok_count != 16'hFFFF)
			tok_count++;
	endfunction

	function automatic void predict_tokens(input sds_pkg::in_t it);
		logic [7:0] c;
		logic [7:0] seen [0:sds_pkg::DelimMax];
		int dlen, m, k, off;
		bit hit, ok;
		sds_pkg::out_t w;
		c = it.char_byte;
		step_words = 0;
		if (cfg_mode == sds_pkg::ModeWhitespace) begin
			held_cnt = 0;
			if (is_space(c)) begin
				if (tok_open) begin
					close_token();
					tok_open = 1'b0;
				end
			end else begin
				tok_open = 1'b1;
				add_word(sds_pkg::KindByte, c);
			end
			if (it.string_end && tok_open) begin
				close_token();
				tok_open = 1'b0;
			end
		end else begin
			dlen = (cfg_dlen > sds_pkg::DelimMax) ? sds_pkg::DelimMax : cfg_dlen;
			tok_open = 1'b0;
			if (dlen == 0) begin
				held_cnt = 0;
			end else begin
				m = held_cnt;
				hit = 1'b0;
				if (m >= dlen)
					m = dlen - 1;
				if (c == delim_at(m)) begin
					m++;
					if (m == dlen) begin
						close_token();
						m = 0;
						hit = 1'b1;
					end
				end else begin
					for (int i = 0; i < m; i++)
						seen[i] = delim_at(i);
					seen[m] = c;
					// Keep the longest tail of the held bytes plus the new byte that can still start a match.
					for (k = m; k > 0; k--) begin
						off = m + 1 - k;
						ok = 1'b1;
						for (int i = 0; i < k; i++) begin
							if (delim_at(i) != seen[off + i]) begin
								ok = 1'b0;
								break;
							end
						end
						if (ok)
							break;
					end
					for (int i = 0; i < m + 1 - k; i++)
						add_word(sds_pkg::KindByte, seen[i]);
					m = k;
				end
				if (it.string_end && !hit) begin
					for (int i = 0; i < m; i++)
						add_word(sds_pkg::KindByte, delim_at(i));
					close_token();
					m = 0;
				end
				held_cnt = m;
			end
		end
		if (it.string_end) begin
			held_cnt = 0;
			tok_open = 1'b0;
			tok_count = '0;
		end
		if (step_words > 0) begin
			w = tok_expected[tok_expected.size()-1];
			w.run_last = 1'b1;
			tok_expected[tok_expected.size()-1] = w;
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		sds_pkg::in_t it;
		it.char_byte = c;
		it.string_end = last;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_tokens(it);
		items_sent++;
	endtask

	task automatic send_string(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && i == s.len() - 1);
	endtask

	task automatic drain();
		int unsigned waited = 0;
		push <= 1'b0;
		while (tok_expected.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sds_pkg::RegIdxBits-1:0] idx,
			input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sds_pkg::RegSplitMode: cfg_mode = value[0];
			sds_pkg::RegDelimBytes: cfg_delim = value;
			sds_pkg::RegDelimLength: cfg_dlen = value[3:0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic set_delimiter(input logic [63:0] chars, input logic [3:0] len);
		write_reg(sds_pkg::RegSplitMode, 64'(sds_pkg::ModeDelimiter));
		write_reg(sds_pkg::RegDelimBytes, chars);
		write_reg(sds_pkg::RegDelimLength, 64'(len));
	endtask

	function automatic logic [7:0] random_char();
		int unsigned r;
		r = $urandom_range(9);
		if (cfg_mode == sds_pkg::ModeWhitespace) begin
			if (r < 4) begin
				case ($urandom_range(5))
					0: return 8'd9;
					1: return 8'd10;
					2: return 8'd11;
					3: return 8'd12;
					4: return 8'd13;
					default: return 8'd32;
				endcase
			end
			if (r < 9)
				return 8'($urandom_range(255));
			return alpha0;
		end
		if (r < 7)
			return $urandom_range(1) ? alpha1 : alpha0;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_string(input int unsigned n, input bit close);
		for (int i = 0; i < n; i++)
			send_char(random_char(), close && i == n - 1);
	endtask

	task automatic random_config(input bit all_regs);
		int unsigned pick;
		logic [63:0] chars;
		logic [3:0] len;
		pick = $urandom_range(2);
		alpha0 = 8'($urandom_range(255));
		alpha1 = 8'($urandom_range(255));
		for (int i = 0; i < 8; i++)
			chars[8*i +: 8] = $urandom_range(1) ? alpha1 : alpha0;
		if ($urandom_range(5) == 0)
			chars = {$urandom, $urandom};
		case ($urandom_range(9))
			0: len = 4'd0;
			1: len = 4'd8;
			2: len = 4'($urandom_range(15, 9));
			3: len = 4'($urandom_range(7, 5));
			default: len = 4'($urandom_range(4, 1));
		endcase
		if (all_regs || pick == 0)
			write_reg(sds_pkg::RegSplitMode, 64'($urandom_range(3) != 0));
		if (all_regs || pick == 1)
			write_reg(sds_pkg::RegDelimBytes, chars);
		if (all_regs || pick == 2)
			write_reg(sds_pkg::RegDelimLength, 64'(len));
	endtask

	task automatic test_whitespace();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		send_string(" \tab  c\n", 1'b1);
		send_string("x", 1'b1);
		send_char(8'd11, 1'b0);
		send_char(8'd12, 1'b0);
		send_char(8'd13, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h7F, 1'b0);
		send_char(8'h08, 1'b0);
		send_char(8'h0E, 1'b0);
		send_char(8'h21, 1'b1);
		drain();
	endtask

	task automatic test_delimiter();
		set_delimiter(64'hFFFF_FFFF_FF62_6161, 4'd3);
		send_string("aaab", 1'b0);
		send_string("aab", 1'b1);
		send_string("aa", 1'b1);
		send_string("ba", 1'b1);
		drain();
	endtask

	task automatic test_config_changes();
		send_string("xa", 1'b0);
		drain();
		write_reg(sds_pkg::RegDelimLength, 64'd1);
		send_string("a", 1'b1);
		send_string("a", 1'b0);
		drain();
		write_reg(sds_pkg::RegSplitMode, 64'(sds_pkg::ModeWhitespace));
		send_string(" k", 1'b0);
		drain();
		write_reg(sds_pkg::RegSplitMode, 64'(sds_pkg::ModeDelimiter));
		send_string("a", 1'b1);
		drain();
		write_reg(sds_pkg::RegDelimLength, 64'd0);
		send_string("ab", 1'b1);
		drain();
		set_delimiter(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		for (int i = 0; i < 8; i++)
			send_char(8'hFF, i == 7);
		drain();
		set_delimiter(64'h0, 4'd2);
		send_char(8'h00, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'h07, 1'b1);
		drain();
	endtask

	task automatic test_random();
		int unsigned target;
		int unsigned r;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			target = items_sent + 90;
			drain();
			random_config(1'b1);
			while (items_sent < target) begin
				r = $urandom_range(9);
				if (r == 0) begin
					drain();
					random_config(1'b1);
				end else if (r == 1) begin
					send_random_string($urandom_range(4, 1), 1'b0);
					drain();
					random_config(1'b0);
					send_random_string($urandom_range(4, 1), 1'b1);
				end else begin
					send_random_string($urandom_range(12, 1), 1'b1);
				end
			end
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_whitespace();
		test_delimiter();
		test_config_changes();
		test_random();
		drain();
		if (tok_expected.size() != 0) begin
			errors += tok_expected.size();
			$display("%0t: %0d expected words never arrived", $time, tok_expected.size());
		end
		$display("Pushed %0d bytes in both split modes, compared %0d words, wrote %0d registers.",
			items_sent, words_checked, cfg_writes);
		$display("Idle and stall mixes, mid-string reconfiguration and odd delimiters ran.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
